[rtl/core/slac_pkg.sv]
// Shared types, constants and helpers for the set-associative LRU cache lookup.
// Used by every module of the block. No dependencies.
package slac_pkg;

  localparam int MAX_SETS = 256;
  localparam int WAYS     = 4;
  localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W    = 32;
  localparam int ADDR_W   = 32;
  localparam int CNT_W    = 32;
  localparam int OFS_W    = 3;
  localparam int IB_W     = 4;
  // Largest index width whose set count still fits in the store.
  localparam int IDX_BITS_MAX = $clog2(MAX_SETS + 1) - 1;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_FETCH = 2'd2;
  localparam logic [1:0] REQ_RSVD  = 2'd3;

  localparam int         CFG_ADDR_W     = 3;
  localparam logic [0:0] CFG_OFFSET_BITS = 1'b0;
  localparam logic [0:0] CFG_INDEX_BITS  = 1'b1;

  localparam logic [OFS_W-1:0] OFFSET_BITS_RST = 3'd6;
  localparam logic [IB_W-1:0]  INDEX_BITS_RST  = 4'd8;

  // One set: tags, state bits and recency order (entry 0 is most recent).
  typedef struct packed {
    logic [WAYS-1:0][TAG_W-1:0] tag;
    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0]            dirty;
    logic [WAYS-1:0][WAY_W-1:0] lru;
  } row_t;

  typedef struct packed {
    logic [OFS_W-1:0] offset_bits;
    logic [IB_W-1:0]  index_bits;
  } cfg_t;

  typedef struct packed {
    logic             hit;
    logic             wb;
    logic [WAY_W-1:0] way;
  } lkup_res_t;

  function automatic row_t reset_row();
    row_t r;
    r = '0;
    for (int p = 0; p < WAYS; p++) begin
      r.lru[p] = WAY_W'(p);
    end
    return r;
  endfunction

endpackage

[rtl/core/set_assoc_lru_cache_lookup_core.sv]
// Set-associative write-back, write-allocate cache tag lookup with true LRU replacement.
// Each request reads its set row from the set memory, then compares tags, picks the way,
// updates the row and writes it back while the result is registered. A new request is
// taken every cycle as long as results are taken, so the sustained rate is one request
// per cycle. That rate is set by the registered set memory read; back-to-back requests
// to the same set are served by forwarding the row just written. Sets not written
// since reset read as empty, so the block needs no clearing pass and is ready right
// after reset.
// Depends on slac_pkg, slac_cfg, slac_tag_mem and slac_lookup.
module set_assoc_lru_cache_lookup_core import slac_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            req_type_i,
  input  logic [ADDR_W-1:0]     mem_address_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  was_hit_o,
  output logic                  did_writeback_o,
  output logic [1:0]            way_used_o,
  output logic [CNT_W-1:0]      count_accesses_o,
  output logic [CNT_W-1:0]      count_hits_o,
  output logic [CNT_W-1:0]      count_misses_o,
  output logic [CNT_W-1:0]      count_writes_o,
  output logic [CNT_W-1:0]      count_writebacks_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  cfg_t             cfg;
  logic [IB_W-1:0]  ib_eff;
  logic [4:0]       tag_shift;
  logic [SET_W:0]   set_mask;
  logic [SET_W-1:0] set_in;
  logic [TAG_W-1:0] tag_in;

  logic             state_q, state_d;
  logic [1:0]       kind_q;
  logic [TAG_W-1:0] tag_q;
  logic [SET_W-1:0] set_q;
  logic             fwd_q;
  row_t             fwd_row_q;
  row_t             mem_row;
  row_t             cur_row;
  row_t             new_row;
  lkup_res_t        res;

  logic             accept;
  logic             done;
  logic             out_valid_q;
  logic             was_hit_q;
  logic             wb_q;
  logic [WAY_W-1:0] way_q;
  logic [CNT_W-1:0] cnt_acc_q, cnt_hit_q, cnt_miss_q, cnt_wr_q, cnt_wb_q;

  slac_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Address split under the current configuration.
  assign ib_eff    = (cfg.index_bits > IB_W'(IDX_BITS_MAX)) ? IB_W'(IDX_BITS_MAX)
                                                            : cfg.index_bits;
  assign tag_shift = 5'(cfg.offset_bits) + 5'(ib_eff);
  assign set_mask  = ((SET_W+1)'(1) << ib_eff) - (SET_W+1)'(1);
  assign set_in    = SET_W'(mem_address_i >> cfg.offset_bits) & set_mask[SET_W-1:0];
  assign tag_in    = TAG_W'(mem_address_i >> tag_shift);

  assign done       = (state_q == ST_LOOK) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == ST_IDLE) || done;
  assign accept     = in_valid_i && in_ready_o;

  slac_tag_mem u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_set_i (set_in),
    .wr_en_i  (done),
    .wr_set_i (set_q),
    .wr_row_i (new_row),
    .rd_row_o (mem_row)
  );

  // The memory reads old data when the set is written in the same cycle.
  assign cur_row = fwd_q ? fwd_row_q : mem_row;

  slac_lookup u_lookup (
    .row_i  (cur_row),
    .kind_i (kind_q),
    .tag_i  (tag_q),
    .row_o  (new_row),
    .res_o  (res)
  );

  always_comb begin
    priority if (accept) begin
      state_d = ST_LOOK;
    end else if (done) begin
      state_d = ST_IDLE;
    end else begin
      state_d = state_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= req_type_i;
      tag_q  <= tag_in;
      set_q  <= set_in;
    end
    if (done) begin
      fwd_row_q <= new_row;
      was_hit_q <= res.hit;
      wb_q      <= res.wb;
      way_q     <= res.way;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_acc_q   <= '0;
      cnt_hit_q   <= '0;
      cnt_miss_q  <= '0;
      cnt_wr_q    <= '0;
      cnt_wb_q    <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        fwd_q <= done && (set_in == set_q);
      end else if (done) begin
        fwd_q <= 1'b0;
      end
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (done) begin
        cnt_acc_q <= cnt_acc_q + CNT_W'(1);
        if (kind_q != REQ_RSVD) begin
          if (res.hit) begin
            cnt_hit_q <= cnt_hit_q + CNT_W'(1);
          end else begin
            cnt_miss_q <= cnt_miss_q + CNT_W'(1);
          end
        end
        if (kind_q == REQ_WRITE) begin
          cnt_wr_q <= cnt_wr_q + CNT_W'(1);
        end
        if (res.wb) begin
          cnt_wb_q <= cnt_wb_q + CNT_W'(1);
        end
      end
    end
  end

  // Counters change only when a new result is loaded, so they serve as result fields.
  assign out_valid_o        = out_valid_q;
  assign was_hit_o          = was_hit_q;
  assign did_writeback_o    = wb_q;
  assign way_used_o         = 2'(way_q);
  assign count_accesses_o   = cnt_acc_q;
  assign count_hits_o       = cnt_hit_q;
  assign count_misses_o     = cnt_miss_q;
  assign count_writes_o     = cnt_wr_q;
  assign count_writebacks_o = cnt_wb_q;

  a_acc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> cnt_acc_q == $past(cnt_acc_q) + CNT_W'(1))
    else $error("access counter did not advance by one");

  a_hit_miss_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> (cnt_hit_q == $past(cnt_hit_q)) || (cnt_miss_q == $past(cnt_miss_q)))
    else $error("request counted as both hit and miss");

  a_wb_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(was_hit_q && wb_q))
    else $error("writeback reported on a hit");

  a_fwd_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> state_q == ST_LOOK)
    else $error("forwarding flag set outside lookup");

  a_no_lost_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> !$changed(cnt_acc_q))
    else $error("result overwritten before it was taken");

endmodule

[rtl/core/slac_cfg.sv]
// APB-style configuration registers: line offset width and set index width.
// Depends on slac_pkg.
module slac_cfg import slac_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic [OFS_W-1:0] offset_bits_q, offset_bits_d;
  logic [IB_W-1:0]  index_bits_q, index_bits_d;
  logic             wr_en;
  logic [0:0]       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    offset_bits_d = offset_bits_q;
    index_bits_d  = index_bits_q;
    if (wr_en) begin
      unique case (reg_sel)
        CFG_OFFSET_BITS: offset_bits_d = pwdata[OFS_W-1:0];
        CFG_INDEX_BITS:  index_bits_d  = pwdata[IB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= OFFSET_BITS_RST;
      index_bits_q  <= INDEX_BITS_RST;
    end else begin
      offset_bits_q <= offset_bits_d;
      index_bits_q  <= index_bits_d;
    end
  end

  always_comb begin
    unique case (reg_sel)
      CFG_OFFSET_BITS: prdata = 32'(offset_bits_q);
      CFG_INDEX_BITS:  prdata = 32'(index_bits_q);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o.offset_bits = offset_bits_q;
  assign cfg_o.index_bits  = index_bits_q;

endmodule

[rtl/core/slac_tag_mem.sv]
// Set memory: one row per set holding tags, valid and dirty bits and LRU order.
// One read and one write port, registered read data. Depends on slac_pkg.
module slac_tag_mem import slac_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [SET_W-1:0] rd_set_i,
  input  logic             wr_en_i,
  input  logic [SET_W-1:0] wr_set_i,
  input  row_t             wr_row_i,
  output row_t             rd_row_o
);

  row_t                mem_q [MAX_SETS];
  row_t                rd_q;
  logic [MAX_SETS-1:0] row_vld_q;
  logic                rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_set_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_set_i];
    end
  end

  // A set never written since reset reads as the reset row, so no clearing pass is needed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_vld_q <= row_vld_q[rd_set_i];
      end
      if (wr_en_i) begin
        row_vld_q[wr_set_i] <= 1'b1;
      end
    end
  end

  assign rd_row_o = rd_vld_q ? rd_q : reset_row();

endmodule

[rtl/core/slac_lookup.sv]
// Tag compare, victim choice and LRU update for one set row.
// Purely combinational. Depends on slac_pkg.
module slac_lookup import slac_pkg::*; (
  input  row_t             row_i,
  input  logic [1:0]       kind_i,
  input  logic [TAG_W-1:0] tag_i,
  output row_t             row_o,
  output lkup_res_t        res_o
);

  logic [WAYS-1:0]  hit_vec;
  logic             hit;
  logic             full;
  logic             access;
  logic             is_write;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] free_way;
  logic [WAY_W-1:0] victim;
  logic [WAY_W-1:0] way;
  logic [WAY_W-1:0] pos;

  assign access   = (kind_i != REQ_RSVD);
  assign is_write = (kind_i == REQ_WRITE);
  assign full     = &row_i.valid;
  assign hit      = |hit_vec;
  assign victim   = row_i.lru[WAYS-1];

  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      hit_vec[w] = row_i.valid[w] && (row_i.tag[w] == tag_i);
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!row_i.valid[w]) begin
        free_way = WAY_W'(w);
      end
    end
  end

  assign way = hit ? hit_way : (full ? victim : free_way);

  // Position of the used way in the recency list; the list is always a permutation.
  always_comb begin
    pos = WAY_W'(WAYS - 1);
    for (int p = WAYS - 1; p >= 0; p--) begin
      if (row_i.lru[p] == way) begin
        pos = WAY_W'(p);
      end
    end
  end

  always_comb begin
    row_o = row_i;
    if (access) begin
      if (hit) begin
        if (is_write) begin
          row_o.dirty[way] = 1'b1;
        end
      end else begin
        row_o.tag[way]   = tag_i;
        row_o.valid[way] = 1'b1;
        row_o.dirty[way] = is_write;
      end
      row_o.lru[0] = way;
      for (int p = 1; p < WAYS; p++) begin
        row_o.lru[p] = (WAY_W'(p) <= pos) ? row_i.lru[p-1] : row_i.lru[p];
      end
    end
  end

  assign res_o.hit = access && hit;
  assign res_o.wb  = access && !hit && full && row_i.dirty[victim];
  assign res_o.way = access ? way : '0;

endmodule

[tb/sv/set_assoc_lru_cache_lookup_core_test.sv]
// Self-checking testbench for set_assoc_lru_cache_lookup_core: random and directed
// requests, APB setup of the address split, and a scoreboard that predicts each lookup.
// Depends on slac_pkg and the RTL of the cache lookup core.
`timescale 1ns / 1ps

module set_assoc_lru_cache_lookup_core_test;
  import slac_pkg::*;

  typedef struct packed {
    logic             hit;
    logic             wb;
    logic [1:0]       way;
    logic [CNT_W-1:0] accesses;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] writes;
    logic [CNT_W-1:0] writebacks;
  } lookup_result_t;

  // Tag-state shadow of the cache plus the queue of lookups still owed by the block.
  class cache_scoreboard;
    logic [TAG_W-1:0] tag_q [MAX_SETS][WAYS];
    bit               line_valid [MAX_SETS][WAYS];
    bit               line_dirty [MAX_SETS][WAYS];
    int               recency [MAX_SETS][WAYS];
    logic [CNT_W-1:0] n_acc, n_hit, n_miss, n_wr, n_wb;
    logic [OFS_W-1:0] offset_bits;
    logic [IB_W-1:0]  index_bits;
    lookup_result_t   owed_q[$];
    int               errors;

    function new();
      for (int s = 0; s < MAX_SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          tag_q[s][w] = '0;
          line_valid[s][w] = 0;
          line_dirty[s][w] = 0;
          recency[s][w] = w;
        end
      end
      n_acc = '0;
      n_hit = '0;
      n_miss = '0;
      n_wr = '0;
      n_wb = '0;
      offset_bits = OFFSET_BITS_RST;
      index_bits = INDEX_BITS_RST;
      errors = 0;
    endfunction

    function void configure(logic [0:0] idx, logic [31:0] val);
      if (idx == CFG_OFFSET_BITS) begin
        offset_bits = val[OFS_W-1:0];
      end else begin
        index_bits = val[IB_W-1:0];
      end
    endfunction

    // Index width actually used: clamped to what the set store holds.
    function int set_bits();
      return (int'(index_bits) > IDX_BITS_MAX) ? IDX_BITS_MAX : int'(index_bits);
    endfunction

    function void note_request(logic [1:0] kind, logic [ADDR_W-1:0] addr);
      int ib;
      int ob;
      int s;
      int way;
      int pos;
      bit hit;
      bit wb;
      bit found;
      logic [TAG_W-1:0] tg;
      lookup_result_t r;
      ib = set_bits();
      ob = int'(offset_bits);
      s = int'((addr >> ob) & ((32'd1 << ib) - 1));
      tg = addr >> (ob + ib);
      hit = 0;
      wb = 0;
      way = 0;
      n_acc++;
      if (kind != REQ_RSVD) begin
        if (kind == REQ_WRITE) n_wr++;
        for (int w = 0; w < WAYS; w++) begin
          if (!hit && line_valid[s][w] && tag_q[s][w] == tg) begin
            hit = 1;
            way = w;
          end
        end
        if (hit) begin
          n_hit++;
          if (kind == REQ_WRITE) line_dirty[s][way] = 1;
        end else begin
          n_miss++;
          found = 0;
          for (int w = 0; w < WAYS; w++) begin
            if (!found && !line_valid[s][w]) begin
              found = 1;
              way = w;
            end
          end
          if (!found) begin
            way = recency[s][WAYS-1];
            if (line_valid[s][way] && line_dirty[s][way]) begin
              wb = 1;
              n_wb++;
            end
          end
          tag_q[s][way] = tg;
          line_valid[s][way] = 1;
          line_dirty[s][way] = (kind == REQ_WRITE);
        end
        pos = WAYS - 1;
        for (int p = WAYS - 1; p >= 0; p--) begin
          if (recency[s][p] == way) pos = p;
        end
        for (int p = pos; p > 0; p--) recency[s][p] = recency[s][p-1];
        recency[s][0] = way;
      end
      r.hit = hit;
      r.wb = wb;
      r.way = 2'(way);
      r.accesses = n_acc;
      r.hits = n_hit;
      r.misses = n_miss;
      r.writes = n_wr;
      r.writebacks = n_wb;
      owed_q.push_back(r);
    endfunction

    function void check_result(lookup_result_t got);
      lookup_result_t exp_r;
      if (owed_q.size() == 0) begin
        $error("lookup result with no request outstanding");
        errors++;
        return;
      end
      exp_r = owed_q.pop_front();
      if (got.hit !== exp_r.hit) begin
        $error("was_hit: expected %0d, got %0d", exp_r.hit, got.hit);
        errors++;
      end
      if (got.wb !== exp_r.wb) begin
        $error("did_writeback: expected %0d, got %0d", exp_r.wb, got.wb);
        errors++;
      end
      if (got.way !== exp_r.way) begin
        $error("way_used: expected %0d, got %0d", exp_r.way, got.way);
        errors++;
      end
      if (got.accesses !== exp_r.accesses) begin
        $error("count_accesses: expected %0d, got %0d", exp_r.accesses, got.accesses);
        errors++;
      end
      if (got.hits !== exp_r.hits) begin
        $error("count_hits: expected %0d, got %0d", exp_r.hits, got.hits);
        errors++;
      end
      if (got.misses !== exp_r.misses) begin
        $error("count_misses: expected %0d, got %0d", exp_r.misses, got.misses);
        errors++;
      end
      if (got.writes !== exp_r.writes) begin
        $error("count_writes: expected %0d, got %0d", exp_r.writes, got.writes);
        errors++;
      end
      if (got.writebacks !== exp_r.writebacks) begin
        $error("count_writebacks: expected %0d, got %0d", exp_r.writebacks, got.writebacks);
        errors++;
      end
    endfunction

    function int owed();
      return owed_q.size();
    endfunction
  endclass

  localparam int ITEMS_PER_PHASE = 180;
  localparam int NUM_PHASES      = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            req_type;
  logic [ADDR_W-1:0]     mem_address;
  logic                  out_valid;
  logic                  out_ready;
  lookup_result_t        dut_result;

  cache_scoreboard sb;
  bit              calm;
  int              stall_left;

  logic [ADDR_W-1:0] hot_sets [4];
  logic [TAG_W-1:0]  hot_tags [6];

  set_assoc_lru_cache_lookup_core i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .req_type_i         (req_type),
    .mem_address_i      (mem_address),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .was_hit_o          (dut_result.hit),
    .did_writeback_o    (dut_result.wb),
    .way_used_o         (dut_result.way),
    .count_accesses_o   (dut_result.accesses),
    .count_hits_o       (dut_result.hits),
    .count_misses_o     (dut_result.misses),
    .count_writes_o     (dut_result.writes),
    .count_writebacks_o (dut_result.writebacks)
  );

  always #4 clk = ~clk;

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: random stall after each taken result, checked on acceptance.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check_result(dut_result);
        stall_left = calm ? 0 : $urandom_range(0, 9);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  function automatic logic [CFG_ADDR_W-1:0] reg_addr(logic [0:0] idx);
    return CFG_ADDR_W'(4 * int'(idx));
  endfunction

  task automatic apb_access(input logic [0:0] idx, input logic wr, input logic [31:0] val);
    logic [31:0] exp_rd;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= reg_addr(idx);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (wr) begin
      sb.configure(idx, val);
    end else begin
      exp_rd = (idx == CFG_OFFSET_BITS) ? 32'(sb.offset_bits) : 32'(sb.index_bits);
      if (prdata !== exp_rd) begin
        $error("prdata reg %0d: expected %0d, got %0d", idx, exp_rd, prdata);
        sb.errors++;
      end
    end
  endtask

  task automatic send_request(input logic [1:0] kind, input logic [ADDR_W-1:0] addr);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    mem_address <= addr;
    do @(posedge clk); while (!in_ready);
    sb.note_request(kind, addr);
  endtask

  function automatic logic [ADDR_W-1:0] compose_addr(logic [TAG_W-1:0] tg,
                                                     logic [ADDR_W-1:0] set_no,
                                                     logic [ADDR_W-1:0] ofs);
    int ob;
    int ib;
    logic [63:0] a;
    ob = int'(sb.offset_bits);
    ib = sb.set_bits();
    a = (64'(tg) << (ob + ib)) | (64'(set_no & ((32'd1 << ib) - 1)) << ob)
        | 64'(ofs & ((32'd1 << ob) - 1));
    return a[ADDR_W-1:0];
  endfunction

  function automatic logic [1:0] random_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return REQ_READ;
    if (r < 72) return REQ_WRITE;
    if (r < 94) return REQ_FETCH;
    return REQ_RSVD;
  endfunction

  // Each phase works on a few sets with a handful of tags so that hits, fills and
  // dirty evictions all happen; the rest are addresses drawn from the whole space.
  task automatic random_phase(input int count);
    logic [TAG_W-1:0] tag_mask;
    int tw;
    tw = 32 - int'(sb.offset_bits) - sb.set_bits();
    tag_mask = TAG_W'((64'd1 << tw) - 1);
    for (int i = 0; i < 4; i++) hot_sets[i] = $urandom;
    hot_tags[0] = tag_mask;
    hot_tags[1] = '0;
    for (int i = 2; i < 6; i++) hot_tags[i] = $urandom & tag_mask;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        send_request(random_kind(),
                     compose_addr(hot_tags[$urandom_range(0, 5)],
                                  hot_sets[$urandom_range(0, 3)], $urandom));
      end else begin
        send_request(random_kind(), $urandom);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.owed() > 0) @(posedge clk);
  endtask

  initial begin
    logic [3:0] ofs_cfg [NUM_PHASES];
    logic [3:0] idx_cfg [NUM_PHASES];
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    req_type = REQ_READ;
    mem_address = '0;
    out_ready = 1'b0;
    calm = 0;
    stall_left = 0;
    ofs_cfg = '{4'd6, 4'd0, 4'd7, 4'd2, 4'd5, 4'd0, 4'd7, 4'd3};
    idx_cfg = '{4'd8, 4'd0, 4'd8, 4'd15, 4'd4, 4'd9, 4'd1, 4'd8};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry: 64-byte lines, 256 sets, so the tag starts at bit 14.
    send_request(REQ_WRITE, 32'h0000_0000);
    send_request(REQ_READ,  32'h0000_0000);
    send_request(REQ_FETCH, 32'h0000_4000);
    send_request(REQ_READ,  32'h0000_8000);
    send_request(REQ_WRITE, 32'h0000_C000);
    // Set 0 is full: the least recent line is the dirty one, so it is written back.
    send_request(REQ_READ,  32'h0001_0000);
    send_request(REQ_READ,  32'h0001_4000);
    send_request(REQ_WRITE, 32'h0000_8000);
    send_request(REQ_READ,  32'h0001_8000);
    send_request(REQ_FETCH, 32'h0001_C000);
    send_request(REQ_RSVD,  32'hFFFF_FFFF);
    send_request(REQ_READ,  32'hFFFF_FFFF);
    send_request(REQ_WRITE, 32'hFFFF_FFFF);
    send_request(REQ_FETCH, 32'hFFFF_FFC0);
    send_request(REQ_READ,  32'h0000_003F);
    send_request(REQ_RSVD,  32'h0000_0000);
    send_request(REQ_WRITE, 32'hAAAA_AAAA);
    send_request(REQ_READ,  32'h5555_5555);
    in_valid <= 1'b0;
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        // Lines already held stay in place and are looked up under the new split.
        apb_access(CFG_OFFSET_BITS, 1'b1, 32'(ofs_cfg[ph]));
        apb_access(CFG_INDEX_BITS, 1'b1, 32'(idx_cfg[ph]));
        apb_access(CFG_OFFSET_BITS, 1'b0, '0);
        apb_access(CFG_INDEX_BITS, 1'b0, '0);
      end
      random_phase(ITEMS_PER_PHASE);
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.owed() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/slac_pkg.sv
rtl/core/slac_cfg.sv
rtl/core/slac_tag_mem.sv
rtl/core/slac_lookup.sv
rtl/core/set_assoc_lru_cache_lookup_core.sv
tb/sv/set_assoc_lru_cache_lookup_core_test.sv
